// ----- hw/rtl/g2e_pkg.sv -----
// shared constants, tables and types of the geodetic to ecef converter
package g2e_pkg;

    // field and port widths
    localparam int LAT_W       = 31;
    localparam int LON_W       = 32;
    localparam int HGT_W       = 28;
    localparam int AXIS_W      = 33;
    localparam int ECC_W       = 37;
    localparam int XYZ_W       = 34;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 1;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_SQUARED = 1'b1;

    // register defaults (wgs84)
    localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0]  ECC_RESET  = 37'd7360548635;

    // q62 and angle constants
    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] THREE_Q62   = 64'hC000_0000_0000_0000;
    localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] DEG2RAD_Q60 = PI_Q60 / 64'd180;
    localparam logic [31:0] DEG_FULL    = 32'd3019898880;
    localparam logic [29:0] DEG_QUARTER = 30'd754974720;
    localparam logic [28:0] DEG_EIGHTH  = 29'd377487360;
    localparam logic [32:0] OUT_LIMIT   = 33'd6500000000;

    // taylor series: divisors of each step, highest power first, and their log2 ceilings
    localparam int TAYLOR_STEPS = 8;
    localparam int SIN_DIV [TAYLOR_STEPS] = '{272, 210, 156, 110, 72, 42, 20, 6};
    localparam int SIN_SHF [TAYLOR_STEPS] = '{9, 8, 8, 7, 7, 6, 5, 3};
    localparam int COS_DIV [TAYLOR_STEPS] = '{240, 182, 132, 90, 56, 30, 12, 2};
    localparam int COS_SHF [TAYLOR_STEPS] = '{8, 8, 8, 7, 6, 5, 4, 1};

    // newton steps of the reciprocal root
    localparam int NEWTON_STEPS = 4;

    // pipeline depths
    localparam int SC_LAT  = 4 * TAYLOR_STEPS + 9;
    localparam int RAD_LAT = 6 * NEWTON_STEPS + 9;

    // sine and cosine as magnitude and sign
    typedef struct packed {
        logic [63:0] sin_mag;
        logic        sin_neg;
        logic [63:0] cos_mag;
        logic        cos_neg;
    } g2e_trig_t;

    typedef struct packed {
        g2e_trig_t lat;
        g2e_trig_t lon;
    } g2e_angle_pair_t;

endpackage

// ----- hw/rtl/g2e_mul.sv -----
// two-stage 64 x 64 multiplier built from four 32 x 32 partial products
module g2e_mul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);
    import g2e_pkg::*;

    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] p_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
        end
    end

    // final sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= {p11_reg, p00_reg} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/g2e_sincos.sv -----
// pipelined sine and cosine of a q23 degree angle by octant reduction and taylor series
module g2e_sincos (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [31:0]   angle,
    output g2e_pkg::g2e_trig_t   trig
);
    import g2e_pkg::*;

    localparam int U_LEN  = 4 * TAYLOR_STEPS + 2;
    localparam int U2_LEN = 4 * TAYLOR_STEPS - 4;
    localparam int OC_LEN = 4 * TAYLOR_STEPS + 7;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [31:0] Q1 = 32'(DEG_QUARTER);
    localparam logic [31:0] Q2 = 32'(DEG_QUARTER) * 32'd2;
    localparam logic [31:0] Q3 = 32'(DEG_QUARTER) * 32'd3;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } oct_t;

    logic [31:0]  wrap;
    logic [31:0]  base;
    logic [1:0]   quad;
    logic [29:0]  rem_reg;
    logic [1:0]   quad_reg;
    logic         swap;
    logic [28:0]  tr_next;
    logic [28:0]  tr_reg;
    oct_t         oct_reg [OC_LEN];
    logic [127:0] pu;
    logic [127:0] pu2;
    logic [127:0] pfin;
    logic [63:0]  u_w;
    logic [63:0]  u2_w;
    logic [63:0]  u_reg [U_LEN];
    logic [63:0]  u2_reg [U2_LEN];
    logic [63:0]  ps_chain [TAYLOR_STEPS+1];
    logic [63:0]  pc_chain [TAYLOR_STEPS+1];
    logic [63:0]  pc_d1_reg;
    logic [63:0]  pc_d2_reg;
    logic [63:0]  s0;
    logic [63:0]  c0;
    logic [63:0]  s_r;
    logic [63:0]  c_r;
    oct_t         oct_end;
    g2e_trig_t    trig_next;
    g2e_trig_t    trig_reg;

    // wrap to one turn and find the quadrant
    always_comb
    begin
        wrap = angle[31] ? (unsigned'(angle) + DEG_FULL) : unsigned'(angle);
        if (wrap >= Q3)
        begin
            quad = QUAD_3;
            base = Q3;
        end
        else if (wrap >= Q2)
        begin
            quad = QUAD_2;
            base = Q2;
        end
        else if (wrap >= Q1)
        begin
            quad = QUAD_1;
            base = Q1;
        end
        else
        begin
            quad = QUAD_0;
            base = 32'd0;
        end
    end

    // fold the upper octant onto the lower one
    always_comb
    begin
        swap    = rem_reg > 30'(DEG_EIGHTH);
        tr_next = swap ? 29'(DEG_QUARTER - rem_reg) : 29'(rem_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg    <= 30'(wrap - base);
            quad_reg   <= quad;
            tr_reg     <= tr_next;
            oct_reg[0] <= '{quad: quad_reg, swap: swap};
            for (int j = 1; j < OC_LEN; j++)
            begin
                oct_reg[j] <= oct_reg[j-1];
            end
        end
    end

    // angle in radians and its square
    g2e_mul u_mul_rad (.clk(clk), .en(en), .a(64'(tr_reg)), .b(DEG2RAD_Q60), .p(pu));
    assign u_w = 64'(pu >> 21);

    g2e_mul u_mul_sq (.clk(clk), .en(en), .a(u_w), .b(u_w), .p(pu2));
    assign u2_w = 64'(pu2 >> 62);

    // carry u and u2 along the series
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0]  <= u_w;
            u2_reg[0] <= u2_w;
            for (int j = 1; j < U_LEN; j++)
            begin
                u_reg[j] <= u_reg[j-1];
            end
            for (int j = 1; j < U2_LEN; j++)
            begin
                u2_reg[j] <= u2_reg[j-1];
            end
        end
    end

    assign ps_chain[0] = ONE_Q62;
    assign pc_chain[0] = ONE_Q62;

    // one horner step per multiplier pair: p = 1 - (u2 * p) / d
    for (genvar i = 0; i < TAYLOR_STEPS; i++)
    begin : g_step
        localparam int SL = SIN_SHF[i];
        localparam int CL = COS_SHF[i];
        localparam logic [63:0] SM =
            64'(((128'd1 << (62 + SL)) + (128'd1 << SL)) / 128'(SIN_DIV[i]));
        localparam logic [63:0] CM =
            64'(((128'd1 << (62 + CL)) + (128'd1 << CL)) / 128'(COS_DIV[i]));

        logic [63:0]  u2_tap;
        logic [63:0]  xs;
        logic [63:0]  xc;
        logic [127:0] pas;
        logic [127:0] pac;
        logic [127:0] pbs;
        logic [127:0] pbc;

        if (i == 0)
        begin : g_first
            assign u2_tap = u2_w;
        end
        else
        begin : g_rest
            assign u2_tap = u2_reg[4*i-1];
        end

        g2e_mul u_mas (.clk(clk), .en(en), .a(u2_tap), .b(ps_chain[i]), .p(pas));
        g2e_mul u_mac (.clk(clk), .en(en), .a(u2_tap), .b(pc_chain[i]), .p(pac));
        assign xs = 64'(pas >> 62);
        assign xc = 64'(pac >> 62);

        // exact division by the step constant through a reciprocal
        g2e_mul u_mbs (.clk(clk), .en(en), .a(xs), .b(SM), .p(pbs));
        g2e_mul u_mbc (.clk(clk), .en(en), .a(xc), .b(CM), .p(pbc));
        assign ps_chain[i+1] = ONE_Q62 - 64'(pbs >> (62 + SL));
        assign pc_chain[i+1] = ONE_Q62 - 64'(pbc >> (62 + CL));
    end

    // sine from the odd series, cosine delayed to match
    g2e_mul u_mul_sin (.clk(clk), .en(en), .a(u_reg[U_LEN-1]), .b(ps_chain[TAYLOR_STEPS]),
                       .p(pfin));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_d1_reg <= pc_chain[TAYLOR_STEPS];
            pc_d2_reg <= pc_d1_reg;
        end
    end

    assign s0      = 64'(pfin >> 62);
    assign c0      = pc_d2_reg;
    assign oct_end = oct_reg[OC_LEN-1];

    // undo octant and quadrant folding
    always_comb
    begin
        s_r = oct_end.swap ? c0 : s0;
        c_r = oct_end.swap ? s0 : c0;
        case (oct_end.quad)
            QUAD_0:  trig_next = '{sin_mag: s_r, sin_neg: 1'b0, cos_mag: c_r, cos_neg: 1'b0};
            QUAD_1:  trig_next = '{sin_mag: c_r, sin_neg: 1'b0, cos_mag: s_r, cos_neg: 1'b1};
            QUAD_2:  trig_next = '{sin_mag: s_r, sin_neg: 1'b1, cos_mag: c_r, cos_neg: 1'b1};
            default: trig_next = '{sin_mag: c_r, sin_neg: 1'b1, cos_mag: s_r, cos_neg: 1'b0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// ----- hw/rtl/g2e_radius.sv -----
// pipelined prime-vertical radius n and n (1 - e2) by newton reciprocal square root
module g2e_radius (
    input  logic                         clk,
    input  logic                         en,
    input  logic [63:0]                  sin_lat,
    input  logic [g2e_pkg::AXIS_W-1:0]   semi_major_axis,
    input  logic [g2e_pkg::ECC_W-1:0]    ecc_squared,
    output logic [63:0]                  n16,
    output logic [63:0]                  nb16
);
    import g2e_pkg::*;

    localparam int W_LEN = 6 * NEWTON_STEPS - 3;

    logic [63:0]  e2q;
    logic [127:0] pss;
    logic [127:0] pes;
    logic [127:0] pn;
    logic [127:0] pnb;
    logic [63:0]  ss;
    logic [63:0]  es;
    logic [63:0]  w_reg [W_LEN];
    logic [63:0]  y_chain [NEWTON_STEPS+1];
    logic [63:0]  y0_reg;
    logic [63:0]  n_w;
    logic [63:0]  n_d1_reg;
    logic [63:0]  n_d2_reg;

    assign e2q = {5'd0, ecc_squared, 22'd0};

    // w = 1 - e2 sin^2
    g2e_mul u_mul_ss (.clk(clk), .en(en), .a(sin_lat), .b(sin_lat), .p(pss));
    assign ss = 64'(pss >> 62);

    g2e_mul u_mul_es (.clk(clk), .en(en), .a(e2q), .b(ss), .p(pes));
    assign es = 64'(pes >> 62);

    // w and the first guess, w carried for the newton steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= ONE_Q62 - es;
            y0_reg   <= ONE_Q62 + (es >> 1);
            for (int j = 1; j < W_LEN; j++)
            begin
                w_reg[j] <= w_reg[j-1];
            end
        end
    end

    assign y_chain[0] = y0_reg;

    // y = y (3 - w y^2) / 2
    for (genvar i = 0; i < NEWTON_STEPS; i++)
    begin : g_newton
        logic [127:0] pyy;
        logic [127:0] pwy;
        logic [127:0] py;
        logic [63:0]  yy;
        logic [63:0]  y_d_reg [4];

        g2e_mul u_mul_yy (.clk(clk), .en(en), .a(y_chain[i]), .b(y_chain[i]), .p(pyy));
        assign yy = 64'(pyy >> 62);

        g2e_mul u_mul_wy (.clk(clk), .en(en), .a(w_reg[6*i+2]), .b(yy), .p(pwy));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_d_reg[0] <= y_chain[i];
                for (int j = 1; j < 4; j++)
                begin
                    y_d_reg[j] <= y_d_reg[j-1];
                end
            end
        end

        g2e_mul u_mul_y (.clk(clk), .en(en), .a(y_d_reg[3]),
                         .b(THREE_Q62 - 64'(pwy >> 62)), .p(py));
        assign y_chain[i+1] = 64'(py >> 63);
    end

    // n = a / sqrt(w) in q16 millimetres, then n (1 - e2)
    g2e_mul u_mul_n (.clk(clk), .en(en), .a({31'd0, semi_major_axis}),
                     .b(y_chain[NEWTON_STEPS]), .p(pn));
    assign n_w = 64'(pn >> 46);

    g2e_mul u_mul_nb (.clk(clk), .en(en), .a(n_w), .b(ONE_Q62 - e2q), .p(pnb));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_d1_reg <= n_w;
            n_d2_reg <= n_d1_reg;
        end
    end

    assign n16  = n_d2_reg;
    assign nb16 = 64'(pnb >> 62);

endmodule

// ----- hw/rtl/geodetic_to_ecef_unit.sv -----
// top level of the geodetic to ecef converter
//
// s_axis carries one geodetic point per transfer: latitude and longitude in
// q23 degrees and ellipsoidal height in millimetres. m_axis returns the
// earth-centred x, y, z in millimetres, saturated to +-6500000000, one result
// per point and in order.
// cfg carries writes to the semi-major axis (index 0) and the eccentricity
// squared (index 1); write them only while no point is in flight.
// Throughput is one point per cycle while the pipeline is not held. A point
// passes through the sine and cosine series, then the newton root and radius
// products, then the final products, rounding and output register; every
// multiply is a two-stage 64 x 64 unit.
// When m_axis stalls, a second output entry catches the point that is in
// transit; while that entry is full the whole pipeline holds and
// s_axis_tready is low, so nothing is dropped or repeated.
// Reset empties the pipeline and loads the wgs84 axis and eccentricity.
module geodetic_to_ecef_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // latitude [30:0], longitude [62:31], height [90:63], zero fill
    input  logic [g2e_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // ecef_x [33:0], ecef_y [67:34], ecef_z [101:68], zero fill
    output logic [g2e_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [g2e_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [g2e_pkg::ECC_W-1:0]             cfg_data
);
    import g2e_pkg::*;

    localparam int T_RAD  = SC_LAT + RAD_LAT;
    localparam int TR_LEN = RAD_LAT + 4;
    localparam int V_LEN  = T_RAD + 8;

    logic                  en;
    logic [AXIS_W-1:0]     axis_reg;
    logic [ECC_W-1:0]      ecc_reg;
    logic                  v_reg [V_LEN];
    logic [HGT_W-1:0]      h_reg [T_RAD];
    g2e_angle_pair_t       tr_reg [TR_LEN];
    g2e_trig_t             lat_trig;
    g2e_trig_t             lon_trig;
    g2e_angle_pair_t       tap_a;
    g2e_angle_pair_t       tap_b;
    logic [63:0]           n16;
    logic [63:0]           nb16;
    logic [HGT_W-1:0]      h_tap;
    logic [63:0]           h_q16;
    logic [63:0]           r_reg;
    logic [63:0]           zr_reg;
    logic [63:0]           r_mag;
    logic [63:0]           zr_mag;
    logic [1:0]            rn_reg;
    logic [1:0]            zn_reg;
    logic [127:0]          prc;
    logic [127:0]          pz;
    logic [127:0]          px;
    logic [127:0]          py;
    logic [63:0]           p_rc;
    logic [63:0]           p_z;
    logic [63:0]           p_x;
    logic [63:0]           p_y;
    logic [63:0]           rc_reg;
    logic [63:0]           rc_mag;
    logic [63:0]           z78_reg;
    logic [63:0]           z79_reg;
    logic [63:0]           z80_reg;
    logic [1:0]            xn_reg;
    logic [1:0]            yn_reg;
    logic [63:0]           v81_reg [3];
    logic [47:0]           m82_reg [3];
    logic                  n82_reg [3];
    logic [32:0]           sat [3];
    logic [XYZ_W-1:0]      res [3];
    logic                  pipe_v;
    logic [OUT_TDATA_W-1:0] pipe_data;
    logic                  out_v_reg;
    logic                  skid_v_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] skid_data_reg;

    // pipeline advances unless the spare output entry is occupied
    assign en            = !skid_v_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_RESET;
            ecc_reg  <= ECC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEMI_MAJOR:  axis_reg <= cfg_data[AXIS_W-1:0];
                REG_ECC_SQUARED: ecc_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // valid bits follow the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < V_LEN; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int j = 1; j < V_LEN; j++)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    // sine and cosine of both angles
    g2e_sincos u_sc_lat (
        .clk   (clk),
        .en    (en),
        .angle ({s_axis_tdata[LAT_W-1], s_axis_tdata[LAT_W-1:0]}),
        .trig  (lat_trig)
    );

    g2e_sincos u_sc_lon (
        .clk   (clk),
        .en    (en),
        .angle (s_axis_tdata[LAT_W+LON_W-1:LAT_W]),
        .trig  (lon_trig)
    );

    // radius of curvature
    g2e_radius u_radius (
        .clk             (clk),
        .en              (en),
        .sin_lat         (lat_trig.sin_mag),
        .semi_major_axis (axis_reg),
        .ecc_squared     (ecc_reg),
        .n16             (n16),
        .nb16            (nb16)
    );

    // height and trig values carried alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg[0]  <= s_axis_tdata[LAT_W+LON_W+HGT_W-1:LAT_W+LON_W];
            tr_reg[0] <= '{lat: lat_trig, lon: lon_trig};
            for (int j = 1; j < T_RAD; j++)
            begin
                h_reg[j] <= h_reg[j-1];
            end
            for (int j = 1; j < TR_LEN; j++)
            begin
                tr_reg[j] <= tr_reg[j-1];
            end
        end
    end

    assign h_tap = h_reg[T_RAD-1];
    assign h_q16 = {{(48-HGT_W){h_tap[HGT_W-1]}}, h_tap, 16'd0};
    assign tap_a = tr_reg[RAD_LAT];
    assign tap_b = tr_reg[RAD_LAT+3];

    // radii plus height
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg  <= n16 + h_q16;
            zr_reg <= nb16 + h_q16;
        end
    end

    // r cos lat and z radius sin lat, sign and magnitude
    assign r_mag  = r_reg[63]  ? (64'd0 - r_reg)  : r_reg;
    assign zr_mag = zr_reg[63] ? (64'd0 - zr_reg) : zr_reg;

    g2e_mul u_mul_rc (.clk(clk), .en(en), .a(r_mag),  .b(tap_a.lat.cos_mag), .p(prc));
    g2e_mul u_mul_z  (.clk(clk), .en(en), .a(zr_mag), .b(tap_a.lat.sin_mag), .p(pz));

    assign p_rc = 64'(prc >> 62);
    assign p_z  = 64'(pz >> 62);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn_reg  <= {rn_reg[0], r_reg[63] ^ tap_a.lat.cos_neg};
            zn_reg  <= {zn_reg[0], zr_reg[63] ^ tap_a.lat.sin_neg};
            rc_reg  <= rn_reg[1] ? (64'd0 - p_rc) : p_rc;
            z78_reg <= zn_reg[1] ? (64'd0 - p_z) : p_z;
            z79_reg <= z78_reg;
            z80_reg <= z79_reg;
        end
    end

    // times cos lon and sin lon
    assign rc_mag = rc_reg[63] ? (64'd0 - rc_reg) : rc_reg;

    g2e_mul u_mul_x (.clk(clk), .en(en), .a(rc_mag), .b(tap_b.lon.cos_mag), .p(px));
    g2e_mul u_mul_y (.clk(clk), .en(en), .a(rc_mag), .b(tap_b.lon.sin_mag), .p(py));

    assign p_x = 64'(px >> 62);
    assign p_y = 64'(py >> 62);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_reg     <= {xn_reg[0], rc_reg[63] ^ tap_b.lon.cos_neg};
            yn_reg     <= {yn_reg[0], rc_reg[63] ^ tap_b.lon.sin_neg};
            v81_reg[0] <= xn_reg[1] ? (64'd0 - p_x) : p_x;
            v81_reg[1] <= yn_reg[1] ? (64'd0 - p_y) : p_y;
            v81_reg[2] <= z80_reg;
        end
    end

    // round half away from zero to whole millimetres
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n82_reg[k] <= v81_reg[k][63];
                m82_reg[k] <= 48'(((v81_reg[k][63] ? (64'd0 - v81_reg[k]) : v81_reg[k])
                                   + 64'd32768) >> 16);
            end
        end
    end

    // saturate and restore the sign
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sat[k] = (m82_reg[k] > 48'(OUT_LIMIT)) ? OUT_LIMIT : 33'(m82_reg[k]);
            res[k] = n82_reg[k] ? (34'd0 - {1'b0, sat[k]}) : {1'b0, sat[k]};
        end
    end

    assign pipe_v    = v_reg[V_LEN-1];
    assign pipe_data = {2'd0, res[2], res[1], res[0]};

    // output register with one spare entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (pipe_v)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (pipe_v)
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                out_data_reg <= pipe_data;
            end
            else
            begin
                skid_data_reg <= pipe_data;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- verif/tb_geodetic_to_ecef_unit.sv -----
// testbench of the geodetic to ecef converter: random and corner points checked against a bit-exact predictor
`timescale 1ns / 100ps

module tb_geodetic_to_ecef_unit;
    import g2e_pkg::*;

    localparam int DRAIN_CYCLES = 90;

    // one converted point
    typedef struct packed {
        logic [XYZ_W-1:0] z;
        logic [XYZ_W-1:0] y;
        logic [XYZ_W-1:0] x;
    } ecef_point_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // latitude [30:0], longitude [62:31], height [90:63], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // ecef_x [33:0], ecef_y [67:34], ecef_z [101:68], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [ECC_W-1:0]       cfg_data;

    // predictor copy of the datum registers
    logic [AXIS_W-1:0] datum_axis;
    logic [ECC_W-1:0]  datum_ecc;

    ecef_point_t expected_points[$];
    int          mismatch_count;
    int          points_sent;
    int          points_checked;
    int          config_writes;
    int          tx_idle_pct;
    int          rx_idle_pct;

    geodetic_to_ecef_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // (a * b) >> s over the full 128-bit product
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // sine and cosine of a q23 degree angle as q62 magnitude and sign
    task automatic angle_trig(input longint deg, output logic [63:0] sin_m, output bit sin_n,
                              output logic [63:0] cos_m, output bit cos_n);
        longint      full;
        longint      quarter;
        longint      r;
        longint      q;
        longint      t;
        bit          swap;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] ps;
        logic [63:0] pc;
        logic [63:0] s0;
        logic [63:0] c0;
        logic [63:0] tmp;
        full = longint'(DEG_FULL);
        quarter = longint'(DEG_QUARTER);
        r = deg % full;
        if (r < 0)
            r += full;
        q = r / quarter;
        t = r % quarter;
        swap = t > longint'(DEG_EIGHTH);
        if (swap)
            t = quarter - t;
        u = mul_shift(64'(t), DEG2RAD_Q60, 21);
        u2 = mul_shift(u, u, 62);
        ps = ONE_Q62;
        pc = ONE_Q62;
        for (int k = 8; k >= 1; k--)
        begin
            ps = ONE_Q62 - mul_shift(u2, ps, 62) / 64'((2 * k) * (2 * k + 1));
            pc = ONE_Q62 - mul_shift(u2, pc, 62) / 64'((2 * k - 1) * (2 * k));
        end
        s0 = mul_shift(u, ps, 62);
        c0 = pc;
        if (swap)
        begin
            tmp = s0;
            s0 = c0;
            c0 = tmp;
        end
        case (q)
            0: begin sin_m = s0; sin_n = 0; cos_m = c0; cos_n = 0; end
            1: begin sin_m = c0; sin_n = 0; cos_m = s0; cos_n = 1; end
            2: begin sin_m = s0; sin_n = 1; cos_m = c0; cos_n = 1; end
            default: begin sin_m = c0; sin_n = 1; cos_m = s0; cos_n = 0; end
        endcase
    endtask

    // signed q16 radius times a signed q62 trig value, truncated toward zero
    function automatic longint scale_by_trig(input longint v, input logic [63:0] m, input bit n);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] p;
        neg = (v < 0) != n;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        p = mul_shift(mag, m, 62);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // q16 millimetres to whole millimetres, half away from zero, saturated
    function automatic logic [XYZ_W-1:0] round_saturate(input longint v);
        bit          neg;
        logic [63:0] m;
        longint      r;
        neg = v < 0;
        m = neg ? 64'(-v) : 64'(v);
        m = (m + 64'd32768) >> 16;
        if (m > 64'(OUT_LIMIT))
            m = 64'(OUT_LIMIT);
        r = neg ? -longint'(m) : longint'(m);
        return r[XYZ_W-1:0];
    endfunction

    // ecef coordinates of one geodetic point under the current datum
    task automatic convert_point(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                                 input logic [HGT_W-1:0] hgt, output ecef_point_t pt);
        logic [63:0] slm, clm, sgm, cgm, e2, w, y, wy2, n16, nb16;
        bit          sln, cln, sgn, cgn;
        longint      h, rad, rc, zr;
        angle_trig(longint'($signed(lat)), slm, sln, clm, cln);
        angle_trig(longint'($signed(lon)), sgm, sgn, cgm, cgn);
        h = longint'($signed(hgt));
        e2 = {27'd0, datum_ecc} << 22;
        w = ONE_Q62 - mul_shift(e2, mul_shift(slm, slm, 62), 62);
        y = ONE_Q62 + ((ONE_Q62 - w) >> 1);
        for (int i = 0; i < NEWTON_STEPS; i++)
        begin
            wy2 = mul_shift(w, mul_shift(y, y, 62), 62);
            y = mul_shift(y, THREE_Q62 - wy2, 63);
        end
        n16 = mul_shift({31'd0, datum_axis}, y, 46);
        nb16 = mul_shift(n16, ONE_Q62 - e2, 62);
        rad = longint'(n16) + h * 65536;
        rc = scale_by_trig(rad, clm, cln);
        zr = longint'(nb16) + h * 65536;
        pt.x = round_saturate(scale_by_trig(rc, cgm, cgn));
        pt.y = round_saturate(scale_by_trig(rc, sgm, sgn));
        pt.z = round_saturate(scale_by_trig(zr, slm, sln));
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got[XYZ_W-1:0]),
                 $signed(want[XYZ_W-1:0]), $realtime);
    endtask

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // compare each result transfer with the oldest expected point
    always @(posedge clk)
    begin
        ecef_point_t got;
        ecef_point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[3*XYZ_W-1:0];
            if (expected_points.size() == 0)
                report_mismatch("unexpected result", 64'(got.x), 64'd0);
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (got.x !== want.x) report_mismatch("ecef_x", 64'(got.x), 64'(want.x));
                if (got.y !== want.y) report_mismatch("ecef_y", 64'(got.y), 64'(want.y));
                if (got.z !== want.z) report_mismatch("ecef_z", 64'(got.z), 64'(want.z));
            end
        end
    end

    // one point transfer, sometimes followed by a random sender gap
    task automatic send_point(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                              input logic [HGT_W-1:0] hgt);
        ecef_point_t pt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, hgt, lon, lat};
        do
            @(posedge clk);
        while (!s_axis_tready);
        convert_point(lat, lon, hgt, pt);
        expected_points.insert(expected_points.size(), pt);
        points_sent++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_datum(input logic [CFG_IDX_W-1:0] idx, input logic [ECC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SEMI_MAJOR)
            datum_axis = value[AXIS_W-1:0];
        else
            datum_ecc = value;
        config_writes++;
    endtask

    task automatic test_datum(input logic [AXIS_W-1:0] axis, input logic [ECC_W-1:0] ecc);
        drain_pipeline();
        write_datum(REG_SEMI_MAJOR, {4'd0, axis});
        write_datum(REG_ECC_SQUARED, ecc);
        cfg_valid <= 1'b0;
    endtask

    // poles, equator, octant edges, wrapped angles and height extremes
    task automatic test_corner_points();
        send_point(31'sd754974720, 32'sd0, 28'sd0);
        send_point(-31'sd754974720, 32'sd0, 28'sd0);
        send_point(31'sd0, 32'sd0, 28'sd0);
        send_point(31'sd0, 32'sd1509949440, 28'sd0);
        send_point(31'sd0, -32'sd1509949440, 28'sd0);
        send_point(31'sd377487360, 32'sd377487360, 28'sd1000);
        send_point(31'sd377487361, 32'sd377487359, -28'sd1000);
        send_point(31'sd754974719, 32'sd754974720, 28'sd100000000);
        send_point(31'sd1, -32'sd1, -28'sd1000000);
        send_point({1'b0, {30{1'b1}}}, {1'b0, {31{1'b1}}}, 28'sd0);
        send_point({1'b1, 30'd0}, {1'b1, 31'd0}, 28'sd0);
        send_point(31'sd0, 32'sd0, {1'b0, {27{1'b1}}});
        send_point(31'sd0, 32'sd0, {1'b1, 27'd0});
        send_point({31{1'b1}}, {32{1'b1}}, {28{1'b1}});
        send_point(31'sd12345678, 32'sd1132462080, 28'sd55555);
        send_point(-31'sd500000000, -32'sd1200000000, 28'sd99999999);
        send_point(31'sd754974720, 32'sd754974720, {1'b0, {27{1'b1}}});
        send_point(31'sd0, 32'sd754974720, {1'b0, {27{1'b1}}});
        send_point(-31'sd754974720, -32'sd754974720, {1'b1, 27'd0});
        send_point(31'sd188743680, 32'sd1321205760, 28'sd1);
    endtask

    // mostly in-range points, some with any bit pattern
    task automatic test_random_points(input int count);
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic [HGT_W-1:0] hgt;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                lat = LAT_W'(longint'($urandom_range(1509949440)) - 64'sd754974720);
                lon = LON_W'(longint'($urandom_range(32'd3019898880)) - 64'sd1509949440);
                hgt = HGT_W'(longint'($urandom_range(101000000)) - 64'sd1000000);
            end
            else
            begin
                lat = LAT_W'($urandom);
                lon = LON_W'($urandom);
                hgt = HGT_W'($urandom);
            end
            send_point(lat, lon, hgt);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SEMI_MAJOR;
        cfg_data <= '0;
        datum_axis = AXIS_RESET;
        datum_ecc = ECC_RESET;
        mismatch_count = 0;
        points_sent = 0;
        points_checked = 0;
        config_writes = 0;
        tx_idle_pct = 20;
        rx_idle_pct = 84;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_points();
        test_random_points(400);

        tx_idle_pct = 84;
        rx_idle_pct = 20;
        test_datum(33'd7000000000, 37'd0);
        test_random_points(150);
        test_datum(33'd6000000000, 37'd68719476736);
        test_corner_points();
        test_random_points(130);
        test_datum(33'd0, {ECC_W{1'b1}});
        test_random_points(100);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_datum({AXIS_W{1'b1}}, 37'd1);
        test_random_points(100);
        test_datum(AXIS_RESET, ECC_RESET);
        test_random_points(250);

        drain_pipeline();
        $display("covered %0d points, %0d results checked, %0d datum writes", points_sent,
                 points_checked, config_writes);
        $display("datums: wgs84, both axis extremes, zero and full eccentricity");
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
